/* src/afc_pkg.sv */
// Package for the airfoil station block: fixed-point constants, station tables,
// and the rounding/saturation helpers shared by the datapath.
// No dependencies.
package afc_pkg;

  // Geometry and number format
  localparam int POINTS      = 128;
  localparam int IDX_W       = 7;
  localparam int LAST        = POINTS - 1;
  localparam int QB          = 30;
  localparam longint QONE    = 64'sd1 <<< QB;
  localparam longint HALF_PI = 64'sd1686629713;

  // Pipeline depths of the iterative units
  localparam int DIV_STAGES  = 31;
  localparam int SQRT_STAGES = 32;

  // Thickness polynomial coefficients (times five, Q30)
  localparam longint C_SQRT = 64'sd1593969738;
  localparam longint C_X1   = -64'sd676457349;
  localparam longint C_X2   = -64'sd1887638127;
  localparam longint C_X3   = 64'sd1526324003;
  localparam longint C_X4   = -64'sd544923976;

  // Horner denominators of the cosine series, (2k-1)(2k) in Q30
  localparam longint COS_DEN1 = QONE * 64'sd2;
  localparam longint COS_DEN2 = QONE * 64'sd12;
  localparam longint COS_DEN3 = QONE * 64'sd30;
  localparam longint COS_DEN4 = QONE * 64'sd56;
  localparam longint COS_DEN5 = QONE * 64'sd90;
  localparam longint COS_DEN6 = QONE * 64'sd132;
  localparam longint COS_DEN7 = QONE * 64'sd182;
  localparam longint COS_DEN8 = QONE * 64'sd240;

  // Register map
  typedef enum logic [1:0] {
    CFG_MAX_CAMBER = 2'd0,
    CFG_CAMBER_POS = 2'd1,
    CFG_THICKNESS  = 2'd2
  } cfg_reg_e;

  localparam logic [15:0] MAX_CAMBER_RST = 16'd0;
  localparam logic [15:0] CAMBER_POS_RST = 16'd26214;
  localparam logic [14:0] THICKNESS_RST  = 15'd7864;

  typedef logic [30:0]        x_tab_t    [POINTS];
  typedef logic signed [31:0] poly_tab_t [POINTS];

  // Taylor-series cosine, Q30, truncating each Horner step
  function automatic longint cos_q30(longint theta);
    longint t2;
    longint r;
    t2 = (theta * theta) >>> QB;
    r  = QONE;
    r  = QONE - (t2 * r) / COS_DEN8;
    r  = QONE - (t2 * r) / COS_DEN7;
    r  = QONE - (t2 * r) / COS_DEN6;
    r  = QONE - (t2 * r) / COS_DEN5;
    r  = QONE - (t2 * r) / COS_DEN4;
    r  = QONE - (t2 * r) / COS_DEN3;
    r  = QONE - (t2 * r) / COS_DEN2;
    r  = QONE - (t2 * r) / COS_DEN1;
    if (r < 0) r = 0;
    if (r > QONE) r = QONE;
    return r;
  endfunction

  // Bitwise integer square root
  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res  = 0;
    rem  = v;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Cosine-spaced station position, Q30
  function automatic longint station_pos(int i);
    longint unsigned u;
    longint unsigned th;
    u  = (longint'(i) <<< QB) / LAST;
    th = (u * longint'(HALF_PI)) >> QB;
    return QONE - cos_q30(longint'(th));
  endfunction

  function automatic x_tab_t build_x_tab();
    x_tab_t tab;
    for (int i = 0; i < POINTS; i++) begin
      tab[i] = 31'(station_pos(i));
    end
    return tab;
  endfunction

  // Thickness polynomial per station, already divided by 2^30
  function automatic poly_tab_t build_poly_tab();
    poly_tab_t tab;
    longint x;
    longint s;
    longint x2;
    longint x3;
    longint x4;
    longint poly;
    for (int i = 0; i < POINTS; i++) begin
      x    = station_pos(i);
      s    = longint'(isqrt64(longint'(x) <<< QB));
      x2   = (x * x) >>> QB;
      x3   = (x2 * x) >>> QB;
      x4   = (x2 * x2) >>> QB;
      poly = C_SQRT * s + C_X1 * x + C_X2 * x2 + C_X3 * x3 + C_X4 * x4;
      poly = poly / QONE;
      tab[i] = 32'(poly);
    end
    return tab;
  endfunction

  localparam x_tab_t    X_TAB    = build_x_tab();
  localparam poly_tab_t POLY_TAB = build_poly_tab();

  // Signed divide by 2^30, truncating toward zero
  function automatic logic signed [33:0] trunc30(logic signed [63:0] v);
    logic signed [63:0] f;
    f = v >>> QB;
    if (v[63] && (v[QB-1:0] != '0)) f = f + 64'sd1;
    return $signed(f[33:0]);
  endfunction

  // Q30 to Q16, round half up, saturate to 18 bits signed
  function automatic logic [17:0] sat_round(logic signed [33:0] v);
    logic signed [34:0] w;
    w = ($signed({v[33], v}) + 35'sd8192) >>> 14;
    if (w > 35'sd131071) w = 35'sd131071;
    if (w < -35'sd131072) w = -35'sd131072;
    return w[17:0];
  endfunction

endpackage

/* src/afc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Requires num_i <= den_i; quotient = floor(num_i * 2^30 / den_i). Uses afc_pkg.
module afc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic [30:0] quot_o
);

  logic [31:0] rem_q [afc_pkg::DIV_STAGES];
  logic [31:0] rem_d [afc_pkg::DIV_STAGES];
  logic [31:0] den_q [afc_pkg::DIV_STAGES];
  logic [31:0] den_d [afc_pkg::DIV_STAGES];
  logic [30:0] quo_q [afc_pkg::DIV_STAGES];
  logic [30:0] quo_d [afc_pkg::DIV_STAGES];

  // One compare-subtract per stage; first stage takes the bit of weight 2^30
  always_comb begin
    for (int k = 0; k < afc_pkg::DIV_STAGES; k++) begin
      logic [32:0] src;
      logic        ge;
      if (k == 0) begin
        src      = {1'b0, num_i};
        den_d[k] = den_i;
        quo_d[k] = '0;
      end else begin
        src      = {rem_q[k-1], 1'b0};
        den_d[k] = den_q[k-1];
        quo_d[k] = quo_q[k-1];
      end
      ge = (src >= {1'b0, den_d[k]});
      rem_d[k] = ge ? 32'(src - {1'b0, den_d[k]}) : src[31:0];
      quo_d[k][30-k] = ge;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q[afc_pkg::DIV_STAGES-1];

endmodule

/* src/afc_sqrt.sv */
// Pipelined bitwise integer square root, one result bit per stage.
// 63-bit radicand, 32-bit root. Uses afc_pkg.
module afc_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [62:0] rad_i,
  output logic [31:0] root_o
);

  logic [63:0] v_q   [afc_pkg::SQRT_STAGES];
  logic [63:0] v_d   [afc_pkg::SQRT_STAGES];
  logic [63:0] res_q [afc_pkg::SQRT_STAGES];
  logic [63:0] res_d [afc_pkg::SQRT_STAGES];

  // Stage k tries the bit of weight 4^(31-k)
  always_comb begin
    for (int k = 0; k < afc_pkg::SQRT_STAGES; k++) begin
      logic [63:0] vs;
      logic [63:0] rs;
      logic [63:0] bitv;
      logic [63:0] trial;
      bitv = 64'd1 << (62 - 2 * k);
      if (k == 0) begin
        vs = {1'b0, rad_i};
        rs = '0;
      end else begin
        vs = v_q[k-1];
        rs = res_q[k-1];
      end
      trial = rs + bitv;
      if (vs >= trial) begin
        v_d[k]   = vs - trial;
        res_d[k] = (rs >> 1) + bitv;
      end else begin
        v_d[k]   = vs;
        res_d[k] = rs >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= v_d;
      res_q <= res_d;
    end
  end

  assign root_o = res_q[afc_pkg::SQRT_STAGES-1][31:0];

endmodule

/* src/airfoil_station_coordinates.sv */
// Four-digit airfoil point generator: top level with config registers and datapath.
// Depends on afc_pkg, afc_div and afc_sqrt.
//
// Usage: each input word carries a station index; the block returns one output
// word with the cosine-spaced station x and the upper and lower surface points,
// all fixed point with 16 fraction bits; surface points saturate to the port ranges.
// Input channel: in_valid_i / in_stall_o / station_index_i. Output channel:
// out_valid_o / out_stall_i and the five coordinate ports. A word moves when
// valid is high and stall is low. Registers max_camber, camber_position and
// thickness are written through cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; ready is always high, and writes belong in idle periods.
// Throughput: one word per cycle while out_stall_i does not hold the pipeline.
// Each word passes through two 31-stage dividers and a 32-stage square root in
// series; the second divider is the sin and cos pair, working in parallel.
// Reset: the pipeline empties and the registers return to 0, 26214 and 7864.
// Stall: while a result waits under out_stall_i the whole pipeline holds and
// in_stall_o is raised; nothing is dropped or repeated.
module airfoil_station_coordinates (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [6:0]         station_index_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        station_x_o,
  output logic signed [17:0] upper_x_o,
  output logic signed [17:0] upper_y_o,
  output logic signed [17:0] lower_x_o,
  output logic signed [17:0] lower_y_o
);

  typedef struct packed {
    logic               vld;
    logic               lt;
    logic [30:0]        x;
    logic signed [31:0] poly;
    logic [30:0]        d;
  } sb1_t;

  typedef struct packed {
    logic               vld;
    logic               lt;
    logic [30:0]        x;
    logic [30:0]        d;
    logic [30:0]        e;
    logic [29:0]        yc;
    logic signed [33:0] yt;
  } sb2_t;

  typedef struct packed {
    logic               vld;
    logic               lt;
    logic [30:0]        x;
    logic [29:0]        yc;
    logic signed [33:0] yt;
  } sb3_t;

  localparam logic [30:0] ONE31 = 31'd1 << afc_pkg::QB;

  logic en;

  // Configuration registers
  logic [15:0] m_q;
  logic [15:0] p_q;
  logic [14:0] t_q;
  logic [29:0] m_full;
  logic [29:0] p_full;
  logic [28:0] t_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= afc_pkg::MAX_CAMBER_RST;
      p_q <= afc_pkg::CAMBER_POS_RST;
      t_q <= afc_pkg::THICKNESS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        afc_pkg::CFG_MAX_CAMBER: m_q <= cfg_data_i;
        afc_pkg::CFG_CAMBER_POS: p_q <= cfg_data_i;
        afc_pkg::CFG_THICKNESS:  t_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign m_full = {m_q, 14'd0};
  assign p_full = {p_q, 14'd0};
  assign t_full = {t_q, 14'd0};

  // Global advance: hold everything while a finished word is stalled
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Stage A: station tables
  logic               va_q;
  logic [30:0]        xa_q;
  logic signed [31:0] polya_q;

  // Stage B: camber branch
  logic               vb_q;
  logic               ltb_q;
  logic [30:0]        xb_q;
  logic signed [31:0] polyb_q;
  logic [30:0]        db_q;
  logic [30:0]        ab_q;
  logic               lt_d;
  logic [30:0]        d_d;
  logic [30:0]        a_d;

  assign lt_d = xa_q < {1'b0, p_full};
  assign d_d  = lt_d ? {1'b0, p_full} : ONE31 - {1'b0, p_full};
  assign a_d  = lt_d ? {1'b0, p_full} - xa_q : xa_q - {1'b0, p_full};

  // Division q = a / d
  logic [30:0] q1;
  sb1_t        sb1_d;
  sb1_t        sb1_q [afc_pkg::DIV_STAGES];

  afc_div u_div_q (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  ({1'b0, ab_q}),
    .den_i  ({1'b0, db_q}),
    .quot_o (q1)
  );

  assign sb1_d = '{vld: vb_q, lt: ltb_q, x: xb_q, poly: polyb_q, d: db_q};

  // Stage C: q^2, camber slope numerator, raw thickness
  sb1_t               c_q;
  logic [30:0]        q2c_q;
  logic [30:0]        ec_q;
  logic signed [61:0] ytpc_q;
  logic [61:0]        qq_d;
  logic [60:0]        mq_d;
  logic signed [61:0] ytp_d;
  sb1_t               c_d;

  assign c_d   = sb1_q[afc_pkg::DIV_STAGES-1];
  assign qq_d  = q1 * q1;
  assign mq_d  = m_full * q1;
  assign ytp_d = $signed({1'b0, t_full}) * c_d.poly;

  // Stage D: camber height, normal-length squares, thickness
  logic               vd_q;
  logic               ltd_q;
  logic [30:0]        xd_q;
  logic [30:0]        dd_q;
  logic [30:0]        ed_q;
  logic [29:0]        ycd_q;
  logic signed [33:0] ytd_q;
  logic [61:0]        dsq_q;
  logic [61:0]        esq_q;
  logic [30:0]        one_m_q2;
  logic [60:0]        ycp_d;

  assign one_m_q2 = ONE31 - q2c_q;
  assign ycp_d    = m_full * one_m_q2;

  // Stage E: radicand
  sb2_t        e_q;
  logic [62:0] hsq_q;

  // Square root h, then sin and cos divisions
  logic [31:0] h;
  sb2_t        sb2_q [afc_pkg::SQRT_STAGES];
  sb2_t        s2o;
  logic [30:0] qs;
  logic [30:0] qc;
  sb3_t        sb3_d;
  sb3_t        sb3_q [afc_pkg::DIV_STAGES];

  afc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (hsq_q),
    .root_o (h)
  );

  assign s2o = sb2_q[afc_pkg::SQRT_STAGES-1];

  afc_div u_div_sin (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  ({1'b0, s2o.e}),
    .den_i  (h),
    .quot_o (qs)
  );

  afc_div u_div_cos (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  ({1'b0, s2o.d}),
    .den_i  (h),
    .quot_o (qc)
  );

  assign sb3_d = '{vld: s2o.vld, lt: s2o.lt, x: s2o.x, yc: s2o.yc, yt: s2o.yt};

  // Stage G: offset products
  sb3_t               g_d;
  logic               vg_q;
  logic [30:0]        xg_q;
  logic [29:0]        ycg_q;
  logic signed [63:0] ysp_q;
  logic signed [63:0] yc2p_q;
  logic signed [31:0] sn_d;
  logic signed [31:0] cs_d;

  assign g_d  = sb3_q[afc_pkg::DIV_STAGES-1];
  assign sn_d = g_d.lt ? $signed({1'b0, qs}) : -$signed({1'b0, qs});
  assign cs_d = $signed({1'b0, qc});

  // Stage H: scale offsets back to Q30
  logic               vh_q;
  logic [30:0]        xh_q;
  logic [29:0]        ych_q;
  logic signed [33:0] ysh_q;
  logic signed [33:0] yc2h_q;

  // Output register
  logic               vo_q;
  logic [16:0]        sx_q;
  logic [17:0]        ux_q;
  logic [17:0]        uy_q;
  logic [17:0]        lx_q;
  logic [17:0]        ly_q;
  logic signed [33:0] xs;
  logic signed [33:0] ycs;
  logic [30:0]        xr;

  assign xs  = $signed({3'd0, xh_q});
  assign ycs = $signed({4'd0, ych_q});
  assign xr  = xh_q + 31'd8192;

  // Pipeline registers: valid bits reset, payload moves with them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vd_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vo_q <= 1'b0;
      c_q.vld <= 1'b0;
      e_q.vld <= 1'b0;
      for (int k = 0; k < afc_pkg::DIV_STAGES; k++) begin
        sb1_q[k].vld <= 1'b0;
        sb3_q[k].vld <= 1'b0;
      end
      for (int k = 0; k < afc_pkg::SQRT_STAGES; k++) begin
        sb2_q[k].vld <= 1'b0;
      end
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      c_q.vld <= c_d.vld;
      vd_q <= c_q.vld;
      e_q.vld <= vd_q;
      vg_q <= g_d.vld;
      vh_q <= vg_q;
      vo_q <= vh_q;
      sb1_q[0].vld <= sb1_d.vld;
      sb3_q[0].vld <= sb3_d.vld;
      sb2_q[0].vld <= e_q.vld;
      for (int k = 1; k < afc_pkg::DIV_STAGES; k++) begin
        sb1_q[k].vld <= sb1_q[k-1].vld;
        sb3_q[k].vld <= sb3_q[k-1].vld;
      end
      for (int k = 1; k < afc_pkg::SQRT_STAGES; k++) begin
        sb2_q[k].vld <= sb2_q[k-1].vld;
      end

      xa_q    <= afc_pkg::X_TAB[station_index_i];
      polya_q <= afc_pkg::POLY_TAB[station_index_i];

      ltb_q   <= lt_d;
      xb_q    <= xa_q;
      polyb_q <= polya_q;
      db_q    <= d_d;
      ab_q    <= a_d;

      sb1_q[0].lt   <= sb1_d.lt;
      sb1_q[0].x    <= sb1_d.x;
      sb1_q[0].poly <= sb1_d.poly;
      sb1_q[0].d    <= sb1_d.d;
      for (int k = 1; k < afc_pkg::DIV_STAGES; k++) begin
        sb1_q[k].lt   <= sb1_q[k-1].lt;
        sb1_q[k].x    <= sb1_q[k-1].x;
        sb1_q[k].poly <= sb1_q[k-1].poly;
        sb1_q[k].d    <= sb1_q[k-1].d;
      end

      c_q.lt   <= c_d.lt;
      c_q.x    <= c_d.x;
      c_q.poly <= c_d.poly;
      c_q.d    <= c_d.d;
      q2c_q    <= qq_d[60:30];
      ec_q     <= mq_d[59:29];
      ytpc_q   <= ytp_d;

      ltd_q <= c_q.lt;
      xd_q  <= c_q.x;
      dd_q  <= c_q.d;
      ed_q  <= ec_q;
      ycd_q <= ycp_d[59:30];
      ytd_q <= afc_pkg::trunc30(64'(ytpc_q));
      dsq_q <= c_q.d * c_q.d;
      esq_q <= ec_q * ec_q;

      e_q.lt <= ltd_q;
      e_q.x  <= xd_q;
      e_q.d  <= dd_q;
      e_q.e  <= ed_q;
      e_q.yc <= ycd_q;
      e_q.yt <= ytd_q;
      hsq_q  <= {1'b0, dsq_q} + {1'b0, esq_q};

      sb2_q[0].lt <= e_q.lt;
      sb2_q[0].x  <= e_q.x;
      sb2_q[0].d  <= e_q.d;
      sb2_q[0].e  <= e_q.e;
      sb2_q[0].yc <= e_q.yc;
      sb2_q[0].yt <= e_q.yt;
      for (int k = 1; k < afc_pkg::SQRT_STAGES; k++) begin
        sb2_q[k].lt <= sb2_q[k-1].lt;
        sb2_q[k].x  <= sb2_q[k-1].x;
        sb2_q[k].d  <= sb2_q[k-1].d;
        sb2_q[k].e  <= sb2_q[k-1].e;
        sb2_q[k].yc <= sb2_q[k-1].yc;
        sb2_q[k].yt <= sb2_q[k-1].yt;
      end

      sb3_q[0].lt <= sb3_d.lt;
      sb3_q[0].x  <= sb3_d.x;
      sb3_q[0].yc <= sb3_d.yc;
      sb3_q[0].yt <= sb3_d.yt;
      for (int k = 1; k < afc_pkg::DIV_STAGES; k++) begin
        sb3_q[k].lt <= sb3_q[k-1].lt;
        sb3_q[k].x  <= sb3_q[k-1].x;
        sb3_q[k].yc <= sb3_q[k-1].yc;
        sb3_q[k].yt <= sb3_q[k-1].yt;
      end

      xg_q   <= g_d.x;
      ycg_q  <= g_d.yc;
      ysp_q  <= $signed(g_d.yt[31:0]) * sn_d;
      yc2p_q <= $signed(g_d.yt[31:0]) * cs_d;

      xh_q   <= xg_q;
      ych_q  <= ycg_q;
      ysh_q  <= afc_pkg::trunc30(ysp_q);
      yc2h_q <= afc_pkg::trunc30(yc2p_q);

      sx_q <= xr[30:14];
      ux_q <= afc_pkg::sat_round(xs - ysh_q);
      uy_q <= afc_pkg::sat_round(ycs + yc2h_q);
      lx_q <= afc_pkg::sat_round(xs + ysh_q);
      ly_q <= afc_pkg::sat_round(ycs - yc2h_q);
    end
  end

  assign out_valid_o = vo_q;
  assign station_x_o = sx_q;
  assign upper_x_o   = $signed(ux_q);
  assign upper_y_o   = $signed(uy_q);
  assign lower_x_o   = $signed(lx_q);
  assign lower_y_o   = $signed(ly_q);

endmodule
